>>> hdl/gf2smv_pkg.sv
package gf2smv_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORD_LOG  = 5;
  localparam int ROWS_DEF  = 256;
  localparam int COLS_DEF  = 512;

  localparam int ROW_IDX_W  = 8;
  localparam int COL_IDX_W  = 9;
  localparam int ROWS_CFG_W = 9;
  localparam int COLS_CFG_W = 10;
  localparam int CNT_W      = 10;
  localparam int WIDX_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [ROWS_CFG_W-1:0] ROWS_CFG_RESET = 9'd256;
  localparam logic [COLS_CFG_W-1:0] COLS_CFG_RESET = 10'd512;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  localparam logic MODE_ENTRY  = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  typedef struct packed {
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] word_bits;
    logic                 length_error;
    logic                 last_word;
  } out_item_t;

endpackage

>>> hdl/gf2smv_ram.sv
module gf2smv_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter int AW    = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/gf2smv_out_stage.sv
module gf2smv_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  gf2smv_pkg::out_item_t item_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gf2smv_pkg::out_item_t item_o
);

  import gf2smv_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign item_o      = item_q;

endmodule

>>> hdl/gf2_sparse_matrix_vector_product.sv
// GF(2) matrix-vector product. The matrix lives in a word-wide memory, one
// column of ROWS bits spread over consecutive words; a second small memory
// holds the row accumulator.
// Input channel (in_valid_i / in_stall_o): a mode 0 item writes one matrix
// entry by read-modify-write. A mode 1 item carries one vector bit; a 1 bit
// inside the column range XORs its column into the accumulator, one memory
// word per cycle. The item is taken only when the controller is idle, so
// one item is in work at a time.
// An item flagged vector_last starts the result: one error item, or one
// item per 32 result rows, each read from the accumulator and then loaded,
// after which the accumulator is cleared. The output register holds a
// stalled item while the controller goes on; out_stall_i only delays
// loading of the next result item.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and must be
// written only while the block is idle.
// After reset the block clears the matrix memory, then the accumulator,
// and only then takes items.
module gf2_sparse_matrix_vector_product #(
  parameter int ROWS = gf2smv_pkg::ROWS_DEF,
  parameter int COLS = gf2smv_pkg::COLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gf2smv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gf2smv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [gf2smv_pkg::ROW_IDX_W-1:0]  row_index_i,
  input  logic [gf2smv_pkg::COL_IDX_W-1:0]  col_index_i,
  input  logic                              entry_bit_i,
  input  logic                              vector_bit_i,
  input  logic                              vector_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gf2smv_pkg::WIDX_W-1:0]     word_index_o,
  output logic [gf2smv_pkg::WORD_BITS-1:0]  word_bits_o,
  output logic                              length_error_o,
  output logic                              last_word_o
);

  import gf2smv_pkg::*;

  localparam int SLICES = (ROWS + WORD_BITS - 1) / WORD_BITS;
  localparam int SL_W   = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int DEPTH  = COLS * SLICES;
  localparam int AW     = $clog2(DEPTH);
  localparam int RE_W   = $clog2(ROWS + 1);

  typedef enum logic [2:0] {
    ST_CLR_MAT, ST_CLR_ACC, ST_IDLE, ST_MAT_WR, ST_ACC, ST_FIN, ST_OUT_RD, ST_OUT_LD
  } state_e;

  state_e                  state_q, state_d;
  logic [ROWS_CFG_W-1:0]   rows_q, rows_d;
  logic [COLS_CFG_W-1:0]   cols_q, cols_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic                    last_q, last_d;
  logic [AW-1:0]           mat_addr_q, mat_addr_d;
  logic [SL_W-1:0]         slice_q, slice_d;
  logic [WORD_LOG-1:0]     bit_pos_q, bit_pos_d;
  logic                    entry_q, entry_d;

  logic                    in_acc;
  logic                    mat_we, mat_re, acc_we, acc_re;
  logic [AW-1:0]           mat_waddr, mat_raddr;
  logic [WORD_BITS-1:0]    mat_wdata, mat_rdata;
  logic [SL_W-1:0]         acc_waddr, acc_raddr;
  logic [WORD_BITS-1:0]    acc_wdata, acc_rdata;
  logic [AW-1:0]           entry_addr, col_base;
  logic                    entry_ok, acc_ok, len_err;
  logic [RE_W-1:0]         rows_eff, rows_m1;
  logic [SL_W-1:0]         words_m1;
  logic [WORD_LOG-1:0]     rem_bits;
  logic [WORD_BITS-1:0]    word_mask;
  logic                    out_load, out_free;
  out_item_t               out_item, out_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign entry_ok   = (32'(row_index_i) < ROWS) && (32'(col_index_i) < COLS);
  assign entry_addr = AW'(32'(col_index_i) * SLICES + 32'(row_index_i >> WORD_LOG));
  assign col_base   = AW'(32'(cnt_q) * SLICES);
  assign acc_ok     = !ovf_q && vector_bit_i && (32'(cnt_q) < 32'(cols_q))
                      && (32'(cnt_q) < COLS);
  assign len_err    = ovf_q || (cnt_q != cols_q) || (32'(cols_q) > COLS);

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = RE_W'(1);
    end else if (32'(rows_q) > ROWS) begin
      rows_eff = RE_W'(ROWS);
    end else begin
      rows_eff = RE_W'(rows_q);
    end
  end

  assign rows_m1   = rows_eff - RE_W'(1);
  assign words_m1  = SL_W'(rows_m1 >> WORD_LOG);
  assign rem_bits  = rows_eff[WORD_LOG-1:0];
  assign word_mask = (rem_bits == '0) ? {WORD_BITS{1'b1}} : ~({WORD_BITS{1'b1}} << rem_bits);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS_IN_USE: rows_d = cfg_data_i[ROWS_CFG_W-1:0];
        CFG_COLS_IN_USE: cols_d = cfg_data_i[COLS_CFG_W-1:0];
        default:         rows_d = rows_q;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    last_d     = last_q;
    mat_addr_d = mat_addr_q;
    slice_d    = slice_q;
    bit_pos_d  = bit_pos_q;
    entry_d    = entry_q;
    mat_we     = 1'b0;
    mat_waddr  = mat_addr_q;
    mat_wdata  = '0;
    mat_re     = 1'b0;
    mat_raddr  = (mode_i == MODE_VECTOR) ? col_base : entry_addr;
    acc_we     = 1'b0;
    acc_waddr  = slice_q;
    acc_wdata  = '0;
    acc_re     = 1'b0;
    acc_raddr  = slice_q;
    out_load   = 1'b0;
    out_item   = '0;

    case (state_q)
      ST_CLR_MAT: begin
        mat_we = 1'b1;
        if (mat_addr_q == AW'(DEPTH - 1)) begin
          slice_d = '0;
          state_d = ST_CLR_ACC;
        end else begin
          mat_addr_d = mat_addr_q + AW'(1);
        end
      end
      ST_CLR_ACC: begin
        acc_we = 1'b1;
        if (slice_q == SL_W'(SLICES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          slice_d = slice_q + SL_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_i == MODE_ENTRY) begin
            if (entry_ok) begin
              mat_re     = 1'b1;
              mat_addr_d = entry_addr;
              bit_pos_d  = row_index_i[WORD_LOG-1:0];
              entry_d    = entry_bit_i;
              state_d    = ST_MAT_WR;
            end
          end else begin
            last_d = vector_last_i;
            if (cnt_q == '1) begin
              ovf_d = 1'b1;
            end else begin
              cnt_d = cnt_q + CNT_W'(1);
            end
            if (acc_ok) begin
              mat_re     = 1'b1;
              acc_re     = 1'b1;
              acc_raddr  = '0;
              mat_addr_d = col_base;
              slice_d    = '0;
              state_d    = ST_ACC;
            end else if (vector_last_i) begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_MAT_WR: begin
        mat_we    = 1'b1;
        mat_wdata = mat_rdata;
        mat_wdata[bit_pos_q] = entry_q;
        state_d   = ST_IDLE;
      end
      ST_ACC: begin
        acc_we    = 1'b1;
        acc_wdata = acc_rdata ^ mat_rdata;
        if (slice_q == SL_W'(SLICES - 1)) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end else begin
          mat_re     = 1'b1;
          acc_re     = 1'b1;
          mat_raddr  = mat_addr_q + AW'(1);
          acc_raddr  = slice_q + SL_W'(1);
          mat_addr_d = mat_addr_q + AW'(1);
          slice_d    = slice_q + SL_W'(1);
        end
      end
      ST_FIN: begin
        if (len_err) begin
          out_load              = 1'b1;
          out_item.length_error = 1'b1;
          out_item.last_word    = 1'b1;
          if (out_free) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            slice_d = '0;
            state_d = ST_CLR_ACC;
          end
        end else begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          slice_d = '0;
          state_d = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        acc_re  = 1'b1;
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_load            = 1'b1;
        out_item.word_index = WIDX_W'(slice_q);
        out_item.last_word  = (slice_q == words_m1);
        out_item.word_bits  = (slice_q == words_m1) ? (acc_rdata & word_mask) : acc_rdata;
        if (out_free) begin
          if (slice_q == words_m1) begin
            slice_d = '0;
            state_d = ST_CLR_ACC;
          end else begin
            slice_d = slice_q + SL_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_CLR_MAT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR_MAT;
      rows_q     <= ROWS_CFG_RESET;
      cols_q     <= COLS_CFG_RESET;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
      mat_addr_q <= '0;
      slice_q    <= '0;
    end else begin
      state_q    <= state_d;
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      last_q     <= last_d;
      mat_addr_q <= mat_addr_d;
      slice_q    <= slice_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_pos_q <= bit_pos_d;
    entry_q   <= entry_d;
  end

  gf2smv_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_matrix_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .re_i    (mat_re),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  gf2smv_ram #(
    .DEPTH (SLICES),
    .WIDTH (WORD_BITS),
    .AW    (SL_W)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  gf2smv_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .item_i      (out_item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (out_q)
  );

  assign word_index_o   = out_q.word_index;
  assign word_bits_o    = out_q.word_bits;
  assign length_error_o = out_q.length_error;
  assign last_word_o    = out_q.last_word;

endmodule

>>> tb/sv/tb_gf2_sparse_matrix_vector_product.sv
module tb_gf2_sparse_matrix_vector_product;
  import gf2smv_pkg::*;

  localparam int COUNT_MAX   = 1023;
  localparam int DRAIN_PAUSE = 64;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i        = MODE_ENTRY;
  logic [ROW_IDX_W-1:0]  row_index_i   = '0;
  logic [COL_IDX_W-1:0]  col_index_i   = '0;
  logic                  entry_bit_i   = 1'b0;
  logic                  vector_bit_i  = 1'b0;
  logic                  vector_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [WIDX_W-1:0]     word_index_o;
  logic [WORD_BITS-1:0]  word_bits_o;
  logic                  length_error_o;
  logic                  last_word_o;

  logic [ROWS_DEF-1:0]   matrix_cols [COLS_DEF];
  logic [ROWS_DEF-1:0]   syndrome_acc;
  logic [CNT_W-1:0]      bits_seen;
  logic                  count_saturated;
  logic [ROWS_CFG_W-1:0] rows_cfg;
  logic [COLS_CFG_W-1:0] cols_cfg;
  out_item_t             syndrome_words_q[$];

  int mismatches = 0;
  int items_sent = 0;
  int stall_run  = 0;
  bit gaps_on    = 1'b1;
  bit stalls_on  = 1'b1;

  gf2_sparse_matrix_vector_product u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .entry_bit_i   (entry_bit_i),
    .vector_bit_i  (vector_bit_i),
    .vector_last_i (vector_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .word_index_o  (word_index_o),
    .word_bits_o   (word_bits_o),
    .length_error_o(length_error_o),
    .last_word_o   (last_word_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic clear_syndrome();
    syndrome_acc    = '0;
    bits_seen       = '0;
    count_saturated = 1'b0;
  endtask

  task automatic syndrome_update(input logic mode, input logic [ROW_IDX_W-1:0] row,
                                 input logic [COL_IDX_W-1:0] col, input logic ent,
                                 input logic vbit, input logic vlast);
    int                   cols_eff;
    int                   rows_eff;
    int                   nwords;
    int                   valid;
    logic [WORD_BITS-1:0] mask;
    out_item_t            w;
    if (mode == MODE_ENTRY) begin
      if (row < ROWS_DEF && col < COLS_DEF) matrix_cols[col][row] = ent;
      return;
    end
    cols_eff = (cols_cfg > COLS_DEF) ? COLS_DEF : int'(cols_cfg);
    if (!count_saturated && vbit && bits_seen < cols_eff) begin
      syndrome_acc ^= matrix_cols[bits_seen];
    end
    if (bits_seen >= COUNT_MAX) count_saturated = 1'b1;
    else bits_seen++;
    if (!vlast) return;
    if (count_saturated || bits_seen != cols_cfg || cols_cfg > COLS_DEF) begin
      w.word_index   = '0;
      w.word_bits    = '0;
      w.length_error = 1'b1;
      w.last_word    = 1'b1;
      syndrome_words_q.push_back(w);
    end else begin
      rows_eff = (rows_cfg == 0) ? 1 : (rows_cfg > ROWS_DEF) ? ROWS_DEF : int'(rows_cfg);
      nwords   = (rows_eff + WORD_BITS - 1) / WORD_BITS;
      for (int s = 0; s < nwords; s++) begin
        valid = rows_eff - s * WORD_BITS;
        mask  = (valid >= WORD_BITS) ? '1 : ((32'd1 << valid) - 32'd1);
        w.word_index   = WIDX_W'(s);
        w.word_bits    = syndrome_acc[s*WORD_BITS +: WORD_BITS] & mask;
        w.length_error = 1'b0;
        w.last_word    = (s == nwords - 1);
        syndrome_words_q.push_back(w);
      end
    end
    clear_syndrome();
  endtask

  task automatic send_item(input logic mode, input logic [ROW_IDX_W-1:0] row,
                           input logic [COL_IDX_W-1:0] col, input logic ent,
                           input logic vbit, input logic vlast);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    row_index_i   <= row;
    col_index_i   <= col;
    entry_bit_i   <= ent;
    vector_bit_i  <= vbit;
    vector_last_i <= vlast;
    do @(posedge clk_i); while (in_stall_o);
    syndrome_update(mode, row, col, ent, vbit, vlast);
    items_sent++;
  endtask

  task automatic write_entry(input int row, input int col, input logic ent);
    send_item(MODE_ENTRY, ROW_IDX_W'(row), COL_IDX_W'(col), ent,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_vector_bit(input logic vbit, input logic vlast);
    send_item(MODE_VECTOR, ROW_IDX_W'($urandom_range(0, 255)),
              COL_IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)), vbit, vlast);
  endtask

  task automatic random_entry_write();
    int lim;
    int col;
    lim = (cols_cfg == 0 || cols_cfg > COLS_DEF) ? COLS_DEF : int'(cols_cfg);
    col = ($urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 511);
    write_entry($urandom_range(0, 255), col, $urandom_range(0, 9) < 7);
  endtask

  task automatic run_product(input int n_bits, input int write_pct);
    for (int i = 0; i < n_bits; i++) begin
      if ($urandom_range(0, 99) < write_pct) random_entry_write();
      send_vector_bit(1'($urandom_range(0, 1)), i == n_bits - 1);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (syndrome_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ROWS_IN_USE) rows_cfg = data[ROWS_CFG_W-1:0];
    else cols_cfg = data[COLS_CFG_W-1:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows_data,
                           input logic [CFG_DATA_W-1:0] cols_data);
    wait_for_results();
    write_register(CFG_ROWS_IN_USE, rows_data);
    write_register(CFG_COLS_IN_USE, cols_data);
  endtask

  task automatic test_full_length_product();
    write_entry(255, 511, 1'b1);
    write_entry(0, 0, 1'b1);
    write_entry(128, 300, 1'b1);
    write_entry(31, 0, 1'b1);
    write_entry(32, 1, 1'b1);
    write_entry(200, 511, 1'b1);
    repeat (8) random_entry_write();
    for (int i = 0; i < COLS_DEF; i++) begin
      send_vector_bit((i == 0 || i == COLS_DEF - 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                      i == COLS_DEF - 1);
    end
  endtask

  task automatic test_directed_cases();
    configure(10'd40, 10'd6);
    write_entry(0, 0, 1'b1);
    write_entry(255, 511, 1'b1);
    write_entry(39, 1, 1'b1);
    write_entry(45, 1, 1'b1);
    write_entry(32, 2, 1'b1);
    write_entry(0, 2, 1'b1);
    write_entry(0, 2, 1'b0);
    send_vector_bit(1'b1, 1'b0);
    send_vector_bit(1'b1, 1'b0);
    send_vector_bit(1'b1, 1'b0);
    write_entry(1, 5, 1'b1);
    send_vector_bit(1'b0, 1'b0);
    send_vector_bit(1'b0, 1'b0);
    send_vector_bit(1'b1, 1'b1);
    run_product(3, 0);
    run_product(8, 0);
  endtask

  task automatic test_register_extremes();
    logic [CFG_DATA_W-1:0] rows_set [6] = '{10'd1, 10'd0, 10'h3FF, 10'd33, 10'd256, 10'd300};
    logic [CFG_DATA_W-1:0] cols_set [6] = '{10'd1, 10'd2, 10'd3, 10'd4, 10'd0, 10'd1023};
    int                    lens     [6] = '{1, 2, 3, 4, 2, 5};
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int k = 0; k < 6; k++) begin
      configure(rows_set[k], cols_set[k]);
      repeat (3) random_entry_write();
      run_product(lens[k], 0);
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_counter_overflow();
    configure(10'd256, 10'd512);
    run_product(COUNT_MAX + 7, 0);
    configure(10'd64, 10'd5);
    run_product(5, 10);
  endtask

  task automatic test_random_products();
    int start;
    int len;
    int rows_pick;
    int cols_pick;
    start = items_sent;
    while (items_sent - start < 320) begin
      if ($urandom_range(0, 7) == 0) begin
        rows_pick = $urandom_range(0, 1) ? 0 : $urandom_range(257, 1023);
      end else begin
        rows_pick = $urandom_range(1, 256) + ($urandom_range(0, 1) ? 512 : 0);
      end
      cols_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      configure(CFG_DATA_W'(rows_pick), CFG_DATA_W'(cols_pick));
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(3, 6)) begin
        repeat ($urandom_range(0, 4)) random_entry_write();
        len = cols_cfg;
        if ($urandom_range(0, 99) < 15) len = len + $urandom_range(0, 6) - 3;
        if (len < 1) len = 1;
        run_product(len, 15);
        if ($urandom_range(0, 9) == 0) wait_for_results();
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_words
    out_item_t exp_w;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (syndrome_words_q.size() == 0) begin
        $error("unexpected item: word_index %0d word_bits %h length_error %0b last_word %0b",
               word_index_o, word_bits_o, length_error_o, last_word_o);
        mismatches++;
      end else begin
        exp_w = syndrome_words_q.pop_front();
        if (word_index_o !== exp_w.word_index) begin
          $error("word_index: expected %0d, got %0d", exp_w.word_index, word_index_o);
          mismatches++;
        end
        if (word_bits_o !== exp_w.word_bits) begin
          $error("word_bits: expected %h, got %h", exp_w.word_bits, word_bits_o);
          mismatches++;
        end
        if (length_error_o !== exp_w.length_error) begin
          $error("length_error: expected %0b, got %0b", exp_w.length_error, length_error_o);
          mismatches++;
        end
        if (last_word_o !== exp_w.last_word) begin
          $error("last_word: expected %0b, got %0b", exp_w.last_word, last_word_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    foreach (matrix_cols[c]) matrix_cols[c] = '0;
    rows_cfg = ROWS_CFG_RESET;
    cols_cfg = COLS_CFG_RESET;
    clear_syndrome();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_length_product();
    test_directed_cases();
    test_register_extremes();
    test_counter_overflow();
    test_random_products();
    wait_for_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> gf2_sparse_matrix_vector_product.f
hdl/gf2smv_pkg.sv
hdl/gf2smv_ram.sv
hdl/gf2smv_out_stage.sv
hdl/gf2_sparse_matrix_vector_product.sv
tb/sv/tb_gf2_sparse_matrix_vector_product.sv
